### hw/rtl/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants for the unsigned-to-decimal ASCII formatter.
// ----------------------------------------------------------------------------
package u2da_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_EMIT
	} state_t;

	localparam int unsigned RUN_W  = 5;
	localparam int unsigned CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [3:0]        CH_DIGIT_HI = 4'h3;

	localparam logic [RUN_W-1:0] FRAME_EXTRA = 5'd3;

endpackage

### hw/rtl/uint_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_core
// Converts an unsigned integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per value. s_tdata carries the value (low
// VALUE_BITS bits used), s_tuser[0] selects plain digits (0) or the bulk
// header framing '$' digits CR LF (1).
// Output channel m_*: one beat per character, most significant digit first,
// no leading zeros. m_tdata[12:8] holds the run length on every beat and
// m_tlast marks the final character.
// Timing: a request is converted by a shared shift/add-3 unit, one value bit
// per cycle, then the digit register drops leading zeros one digit per cycle,
// then the text streams out at one character per cycle while m_tready is
// high. The next request is taken in the cycle after the last beat.
// s_tready is low while a request is in flight.
// Reset: arst_n clears the sequencer; the block comes up idle and ready.
// Stall: when m_tready is low the current beat is held unchanged.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii_core #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_char, [12:8] run_length, [15:13] zero
	output logic        m_tlast    // last
);

	localparam int unsigned NDIG = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int unsigned BCD_W = NDIG * 4;
	localparam int unsigned CW = $clog2(VALUE_BITS + 1);
	localparam int unsigned DW = $clog2(NDIG + 1);

	u2da_pkg::state_t state_q, state_d;

	logic [VALUE_BITS-1:0]        val_q;
	logic [BCD_W-1:0]             bcd_q;
	logic [CW-1:0]                cnt_q;
	logic [DW-1:0]                ndig_q;
	logic                         bulk_q;
	logic [u2da_pkg::RUN_W-1:0]   pos_q;

	logic [BCD_W-1:0]             bcd_adj;
	logic [3:0]                   top_dig;
	logic                         lead_zero;
	logic [u2da_pkg::RUN_W-1:0]   run_len;
	logic                         is_last;
	logic                         is_digit;
	logic [u2da_pkg::CHAR_W-1:0]  out_char;
	logic                         out_fire;

	assign top_dig   = bcd_q[BCD_W-1 -: 4];
	assign lead_zero = (top_dig == 4'd0) && (ndig_q > DW'(1));

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			u2da_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = u2da_pkg::ST_CONV;
			end
			u2da_pkg::ST_CONV: begin
				if (cnt_q == CW'(1)) state_d = u2da_pkg::ST_NORM;
			end
			u2da_pkg::ST_NORM: begin
				if (!lead_zero) state_d = u2da_pkg::ST_EMIT;
			end
			u2da_pkg::ST_EMIT: begin
				if (m_tready && is_last) state_d = u2da_pkg::ST_IDLE;
			end
			default: state_d = u2da_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		run_len  = u2da_pkg::RUN_W'(ndig_q) + (bulk_q ? u2da_pkg::FRAME_EXTRA : '0);
		is_last  = (pos_q == run_len - u2da_pkg::RUN_W'(1));
		is_digit = 1'b1;
		out_char = {u2da_pkg::CH_DIGIT_HI, top_dig};
		if (bulk_q) begin
			if (pos_q == '0) begin
				out_char = u2da_pkg::CH_DOLLAR;
				is_digit = 1'b0;
			end else if (pos_q == run_len - u2da_pkg::RUN_W'(2)) begin
				out_char = u2da_pkg::CH_CR;
				is_digit = 1'b0;
			end else if (is_last) begin
				out_char = u2da_pkg::CH_LF;
				is_digit = 1'b0;
			end
		end
		s_tready = (state_q == u2da_pkg::ST_IDLE);
		m_tvalid = (state_q == u2da_pkg::ST_EMIT);
		m_tdata  = {3'b000, run_len, out_char};
		m_tlast  = is_last;
		out_fire = m_tvalid && m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2da_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			u2da_pkg::ST_IDLE: begin
				val_q  <= s_tdata[VALUE_BITS-1:0];
				bulk_q <= s_tuser[0];
				bcd_q  <= '0;
				cnt_q  <= CW'(VALUE_BITS);
				ndig_q <= DW'(NDIG);
				pos_q  <= '0;
			end
			u2da_pkg::ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VALUE_BITS-1]};
				val_q <= val_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			u2da_pkg::ST_NORM: begin
				if (lead_zero) begin
					bcd_q  <= bcd_q << 4;
					ndig_q <= ndig_q - DW'(1);
				end
			end
			u2da_pkg::ST_EMIT: begin
				if (out_fire) begin
					pos_q <= pos_q + u2da_pkg::RUN_W'(1);
					if (is_digit) bcd_q <= bcd_q << 4;
				end
			end
			default: begin
				pos_q <= '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("block did not return to idle after the final character");

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12:8] != 5'd0) && (m_tdata[12:8] <= 5'd23))
		else $error("run length out of range");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream test of uint_to_decimal_ascii_core. Each value request is predicted
// into its expected ASCII characters (plain digits or '$' digits CR LF, with
// run length and last flag). Every output character is checked against that
// prediction. Directed edge values come first, then random values. Random gaps
// and stalls on both channels apply throughout, off for some random stretches.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic CMD_PLAIN = 1'b0;
	localparam logic CMD_BULK  = 1'b1;

	localparam logic [u2da_pkg::CHAR_W-1:0] CH_ZERO = {u2da_pkg::CH_DIGIT_HI, 4'h0};

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct packed {
		logic [u2da_pkg::CHAR_W-1:0] ch;
		logic [u2da_pkg::RUN_W-1:0]  len;
		logic                        last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [63:0] value
	logic [0:0]  s_tuser = '0;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] out_char, [12:8] run_length, [15:13] zero
	logic        m_tlast;

	text_char_t expected_chars[$];
	int         mismatches = 0;
	int         quiet_cycles = 0;
	bit         pace_gaps = 1'b1;

	uint_to_decimal_ascii_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] power_of_ten(input int exponent);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < exponent; k++) p = p * 64'd10;
		return p;
	endfunction

	function automatic void queue_text(input logic cmd, input logic [63:0] value);
		logic [u2da_pkg::CHAR_W-1:0] digits[$];
		logic [u2da_pkg::CHAR_W-1:0] text[$];
		logic [63:0]                 rest;
		text_char_t                  c;
		rest = value;
		do begin
			digits.push_front(CH_ZERO + u2da_pkg::CHAR_W'(rest % 64'd10));
			rest = rest / 64'd10;
		end while (rest != 64'd0);
		if (cmd == CMD_BULK) text.push_back(u2da_pkg::CH_DOLLAR);
		foreach (digits[i]) text.push_back(digits[i]);
		if (cmd == CMD_BULK) begin
			text.push_back(u2da_pkg::CH_CR);
			text.push_back(u2da_pkg::CH_LF);
		end
		foreach (text[i]) begin
			c.ch   = text[i];
			c.len  = u2da_pkg::RUN_W'(text.size());
			c.last = (i == text.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// hold valid across back-to-back requests; drop it only for a gap
	task automatic send_request(input logic cmd, input logic [63:0] value);
		int gap;
		gap = pace_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= cmd;
		queue_text(cmd, value);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic test_zero_value();
		send_request(CMD_PLAIN, 64'd0);
		send_request(CMD_BULK, 64'd0);
	endtask

	task automatic test_extreme_values();
		send_request(CMD_PLAIN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(CMD_BULK, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(CMD_PLAIN, 64'd1);
		send_request(CMD_BULK, 64'd9);
		send_request(CMD_PLAIN, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_BULK, 64'h5555_5555_5555_5555);
		send_request(CMD_PLAIN, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_digit_count_edges();
		for (int e = 1; e <= 19; e += 6) begin
			send_request(CMD_PLAIN, power_of_ten(e) - 64'd1);
			send_request(CMD_BULK, power_of_ten(e));
		end
		send_request(CMD_PLAIN, power_of_ten(18));
		send_request(CMD_BULK, power_of_ten(18) - 64'd1);
		send_request(CMD_PLAIN, power_of_ten(19) - 64'd1);
		send_request(CMD_BULK, power_of_ten(19) - 64'd1);
		send_request(CMD_PLAIN, power_of_ten(19));
		send_request(CMD_BULK, power_of_ten(19) + 64'd1);
	endtask

	task automatic test_random_values(input int count);
		logic [63:0] v;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) pace_gaps = ($urandom_range(0, 3) != 0);
			v = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: ;
				1: v = v >> $urandom_range(0, 63);
				2: v = power_of_ten($urandom_range(0, 19)) - 64'($urandom_range(0, 1));
				default: v = v >> $urandom_range(40, 63);
			endcase
			send_request(1'($urandom_range(0, 1)), v);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_value();
		test_extreme_values();
		test_digit_count_edges();
		test_random_values(350);
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// stall the output channel per character
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = pace_gaps ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("unexpected character", m_tdata, 0);
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata[7:0] !== want.ch) report_mismatch("out_char", m_tdata[7:0], want.ch);
				if (m_tdata[12:8] !== want.len)
					report_mismatch("run_length", m_tdata[12:8], want.len);
				if (m_tdata[15:13] !== 3'b000) report_mismatch("pad bits", m_tdata[15:13], 0);
				if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
